// File: src/i2c_master_subaddr_sequencer_assert.svh
// ----------------------------------------------------------------------------
// i2c_master_subaddr_sequencer assertion macros
// Clocked assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_SUBADDR_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_SUBADDR_SEQUENCER_ASSERT_SVH

// assertion gated off while reset is held
`define I2CMS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("i2cms assertion failed");

// assertion that also holds through reset
`define I2CMS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("i2cms reset assertion failed");

`endif

// File: src/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and codes for the I2C master sub-address sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  // done status
  localparam logic [1:0] DONE_BUSY   = 2'd0;
  localparam logic [1:0] DONE_OK     = 2'd1;
  localparam logic [1:0] DONE_FAIL   = 2'd2;
  localparam logic [1:0] DONE_REJECT = 2'd3;

  // ack enable control
  localparam logic [1:0] ACK_LEAVE = 2'd0;
  localparam logic [1:0] ACK_SET   = 2'd1;
  localparam logic [1:0] ACK_CLEAR = 2'd2;

  // sub-address phase
  localparam logic [1:0] PHASE_NONE  = 2'd0;
  localparam logic [1:0] PHASE_READ  = 2'd1;
  localparam logic [1:0] PHASE_WRITE = 2'd2;

  // sub-address mode
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_ONE  = 2'd1;
  localparam logic [1:0] MODE_TWO  = 2'd2;
  localparam logic [1:0] MODE_8X   = 2'd3;

  // request kind
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_EVENT = 1'b1;

  // engine status codes, low three bits masked
  localparam logic [7:0] ST_MASK      = 8'hF8;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RSTART    = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK = 8'h48;
  localparam logic [7:0] ST_RX_ACK    = 8'h50;
  localparam logic [7:0] ST_RX_NACK   = 8'h58;

  typedef struct packed {
    logic [7:0]  slave_byte;
    logic [15:0] sub_addr;
    logic [1:0]  sub_left;
    logic [1:0]  sub_phase;
    logic [1:0]  end_state;
  } seq_state_t;

  typedef struct packed {
    logic       load_data;
    logic [7:0] data_out;
    logic       took_tx;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       set_start;
    logic       set_stop;
    logic [1:0] ack_control;
    logic       clear_start;
    logic       clear_irq;
    logic [1:0] done_status;
  } seq_result_t;

endpackage

// File: src/i2cms_step.sv
// ----------------------------------------------------------------------------
// i2cms_step
// Next state and result for one request: start setup or status event.
// ----------------------------------------------------------------------------
module i2cms_step #(
  parameter int COUNT_WIDTH = i2cms_pkg::COUNT_WIDTH_DEF
) (
  input  logic                     action,
  input  logic [7:0]               slave_addr,
  input  logic                     is_read,
  input  logic [1:0]               sub_mode,
  input  logic [15:0]              sub_address,
  input  logic [15:0]              byte_count,
  input  logic [7:0]               bus_status,
  input  logic [7:0]               rx_byte,
  input  logic [7:0]               tx_byte,
  input  i2cms_pkg::seq_state_t    st_cur,
  input  logic [COUNT_WIDTH-1:0]   left_cur,
  output i2cms_pkg::seq_state_t    st_nxt,
  output logic [COUNT_WIDTH-1:0]   left_nxt,
  output i2cms_pkg::seq_result_t   res
);
  import i2cms_pkg::*;

  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] left_dec;
  logic [COUNT_WIDTH-1:0] rx_left;
  logic [7:0]             st_code;
  logic [7:0]             sla_sum;
  logic [7:0]             sla_8x;

  assign cnt      = COUNT_WIDTH'(byte_count);
  assign left_dec = left_cur - COUNT_WIDTH'(1);
  assign rx_left  = (left_cur != '0) ? left_dec : left_cur;
  assign st_code  = bus_status & ST_MASK;
  assign sla_sum  = slave_addr + {7'd0, is_read};
  assign sla_8x   = sla_sum + {4'd0, sub_address[10:8], 1'b0};

  always_comb begin
    st_nxt   = st_cur;
    left_nxt = left_cur;
    res      = '0;
    if (action == ACT_START) begin
      if (cnt == '0) begin
        res.done_status = DONE_REJECT;
      end else begin
        case (sub_mode)
          MODE_NONE: begin
            st_nxt.sub_left  = 2'd0;
            st_nxt.sub_phase = PHASE_NONE;
            st_nxt.slave_byte = sla_sum;
          end
          MODE_8X: begin
            st_nxt.sub_addr   = {8'd0, sub_address[7:0]};
            st_nxt.sub_left   = 2'd1;
            st_nxt.sub_phase  = is_read ? PHASE_READ : PHASE_WRITE;
            st_nxt.slave_byte = sla_8x;
          end
          default: begin
            st_nxt.sub_addr   = sub_address;
            st_nxt.sub_left   = sub_mode;
            st_nxt.sub_phase  = is_read ? PHASE_READ : PHASE_WRITE;
            st_nxt.slave_byte = sla_sum;
          end
        endcase
        left_nxt         = cnt;
        st_nxt.end_state = DONE_BUSY;
        res.set_start    = 1'b1;
        res.ack_control  = ACK_CLEAR;
        res.clear_start  = 1'b1;
        res.clear_irq    = 1'b1;
      end
    end else begin
      case (st_code)
        ST_START: begin
          res.load_data   = 1'b1;
          res.data_out    = (st_cur.sub_phase == PHASE_READ) ?
                            (st_cur.slave_byte & 8'hFE) : st_cur.slave_byte;
          res.clear_start = 1'b1;
          res.clear_irq   = 1'b1;
        end
        ST_RSTART: begin
          res.load_data   = 1'b1;
          res.data_out    = st_cur.slave_byte;
          res.clear_start = 1'b1;
          res.clear_irq   = 1'b1;
        end
        ST_SLAW_ACK, ST_DATA_ACK: begin
          if (st_cur.sub_phase == PHASE_NONE) begin
            if (left_cur != '0) begin
              res.load_data = 1'b1;
              res.data_out  = tx_byte;
              res.took_tx   = 1'b1;
              left_nxt      = left_dec;
            end else begin
              res.set_stop     = 1'b1;
              st_nxt.end_state = DONE_OK;
            end
            res.clear_start = 1'b1;
            res.clear_irq   = 1'b1;
          end else if (st_cur.sub_phase == PHASE_READ ||
                       st_cur.sub_phase == PHASE_WRITE) begin
            if (st_cur.sub_left == 2'd2) begin
              res.load_data   = 1'b1;
              res.data_out    = st_cur.sub_addr[15:8];
              res.clear_start = 1'b1;
              res.clear_irq   = 1'b1;
              st_nxt.sub_left = 2'd1;
            end else if (st_cur.sub_left == 2'd1) begin
              res.load_data   = 1'b1;
              res.data_out    = st_cur.sub_addr[7:0];
              res.clear_start = 1'b1;
              res.clear_irq   = 1'b1;
              st_nxt.sub_left = 2'd0;
              if (st_cur.sub_phase == PHASE_WRITE) begin
                st_nxt.sub_phase = PHASE_NONE;
              end
            end else if (st_cur.sub_left == 2'd0 &&
                         st_cur.sub_phase == PHASE_READ) begin
              // repeated start before the read
              res.set_start    = 1'b1;
              res.clear_irq    = 1'b1;
              st_nxt.sub_phase = PHASE_NONE;
            end
          end
        end
        ST_SLAR_ACK: begin
          res.ack_control = (left_cur <= COUNT_WIDTH'(1)) ? ACK_CLEAR : ACK_SET;
          res.clear_start = 1'b1;
          res.clear_irq   = 1'b1;
        end
        ST_SLAW_NACK, ST_DATA_NACK, ST_ARB_LOST, ST_SLAR_NACK: begin
          res.clear_start  = 1'b1;
          res.clear_irq    = 1'b1;
          st_nxt.end_state = DONE_FAIL;
        end
        ST_RX_ACK: begin
          res.rx_valid    = 1'b1;
          res.rx_data     = rx_byte;
          left_nxt        = rx_left;
          res.ack_control = (rx_left == COUNT_WIDTH'(1)) ? ACK_CLEAR : ACK_SET;
          res.clear_start = 1'b1;
          res.clear_irq   = 1'b1;
        end
        ST_RX_NACK: begin
          res.rx_valid     = 1'b1;
          res.rx_data      = rx_byte;
          res.set_stop     = 1'b1;
          res.clear_start  = 1'b1;
          res.clear_irq    = 1'b1;
          st_nxt.end_state = DONE_OK;
        end
        default: begin
        end
      endcase
      res.done_status = st_nxt.end_state;
    end
  end

endmodule

// File: src/i2c_master_subaddr_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_subaddr_sequencer
// Accepted results are registered in the output register, or in the skid when
// the output stalls. Throughput: one request per cycle while the skid is empty;
// this two-entry buffer keeps in_ready high while one result waits.
// Reset: synchronous active-low rst_n clears sequencer state and buffer valids.
// ----------------------------------------------------------------------------
module i2c_master_subaddr_sequencer #(
  parameter int COUNT_WIDTH = i2cms_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_slave_addr,
  input  logic        in_is_read,
  input  logic [1:0]  in_sub_mode,
  input  logic [15:0] in_sub_address,
  input  logic [15:0] in_byte_count,
  input  logic [7:0]  in_bus_status,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_tx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_load_data,
  output logic [7:0]  out_data_out,
  output logic        out_took_tx,
  output logic        out_rx_valid,
  output logic [7:0]  out_rx_data,
  output logic        out_set_start,
  output logic        out_set_stop,
  output logic [1:0]  out_ack_control,
  output logic        out_clear_start,
  output logic        out_clear_irq,
  output logic [1:0]  out_done_status
);
  import i2cms_pkg::*;

  seq_state_t             st_r, st_nxt;
  logic [COUNT_WIDTH-1:0] left_r, left_nxt;
  seq_result_t            res;
  seq_result_t            out_res_r, out_res_nxt;
  seq_result_t            skid_res_r, skid_res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   skid_valid_r, skid_valid_nxt;
  logic                   accept;
  logic                   out_free;

  i2cms_step #(.COUNT_WIDTH(COUNT_WIDTH)) u_step (
    .action      (in_action),
    .slave_addr  (in_slave_addr),
    .is_read     (in_is_read),
    .sub_mode    (in_sub_mode),
    .sub_address (in_sub_address),
    .byte_count  (in_byte_count),
    .bus_status  (in_bus_status),
    .rx_byte     (in_rx_byte),
    .tx_byte     (in_tx_byte),
    .st_cur      (st_r),
    .left_cur    (left_r),
    .st_nxt      (st_nxt),
    .left_nxt    (left_nxt),
    .res         (res)
  );

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = accept;
        skid_res_nxt   = res;
      end else begin
        out_valid_nxt = accept;
        out_res_nxt   = res;
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= '0;
      left_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        st_r   <= st_nxt;
        left_r <= left_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_load_data   = out_res_r.load_data;
  assign out_data_out    = out_res_r.data_out;
  assign out_took_tx     = out_res_r.took_tx;
  assign out_rx_valid    = out_res_r.rx_valid;
  assign out_rx_data     = out_res_r.rx_data;
  assign out_set_start   = out_res_r.set_start;
  assign out_set_stop    = out_res_r.set_stop;
  assign out_ack_control = out_res_r.ack_control;
  assign out_clear_start = out_res_r.clear_start;
  assign out_clear_irq   = out_res_r.clear_irq;
  assign out_done_status = out_res_r.done_status;

endmodule

// File: src/i2cms_checker.sv
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks on the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_master_subaddr_sequencer_assert.svh"

module i2cms_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_load_data,
  input logic [7:0] out_data_out,
  input logic       out_took_tx,
  input logic       out_rx_valid,
  input logic [7:0] out_rx_data,
  input logic       out_set_start,
  input logic       out_set_stop,
  input logic [1:0] out_ack_control,
  input logic       out_clear_start,
  input logic       out_clear_irq,
  input logic [1:0] out_done_status
);
  import i2cms_pkg::*;

  logic       stall;
  logic [9:0] out_key;
  logic       reject_quiet;
  logic       fields_zero;

  assign stall        = out_valid && !out_ready;
  assign out_key      = {out_data_out, out_done_status};
  assign reject_quiet = !out_load_data && !out_set_start && !out_set_stop &&
                        !out_clear_start && !out_clear_irq && !out_rx_valid &&
                        out_ack_control == ACK_LEAVE;
  assign fields_zero  = (out_load_data || out_data_out == 8'd0) &&
                        (out_rx_valid || out_rx_data == 8'd0) &&
                        (!out_took_tx || out_load_data);

  // stalled result holds
  `I2CMS_ASSERT(a_out_hold, stall |=> out_valid && $stable(out_key))

  // rejected start drives no controls
  `I2CMS_ASSERT(a_reject_quiet, out_valid && out_done_status == DONE_REJECT |-> reject_quiet)

  // idle byte fields are zero
  `I2CMS_ASSERT(a_zero_fields, out_valid |-> fields_zero)

  // nothing offered straight after reset
  `I2CMS_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind i2c_master_subaddr_sequencer i2cms_checker u_i2cms_checker (.*);

// File: bench/i2c_master_subaddr_sequencer_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_subaddr_sequencer_tb
// Self-checking bench: drives start and engine-status requests with random
// gaps and back-pressure, predicts every result in a scoreboard and compares
// each one field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import i2cms_pkg::*;

typedef struct packed {
  logic        action;
  logic [7:0]  slave_addr;
  logic        is_read;
  logic [1:0]  sub_mode;
  logic [15:0] sub_address;
  logic [15:0] byte_count;
  logic [7:0]  bus_status;
  logic [7:0]  rx_byte;
  logic [7:0]  tx_byte;
} seq_req_t;

class seq_scoreboard;
  logic [7:0]                 slave_byte;
  logic [15:0]                sub_addr;
  logic [1:0]                 sub_left;
  logic [1:0]                 sub_phase;
  logic [1:0]                 end_state;
  logic [COUNT_WIDTH_DEF-1:0] bytes_left;
  seq_result_t                pending_results[$];
  int                         errors;
  int                         checked;
  int                         n_start;
  int                         n_reject;
  int                         n_stop;
  int                         n_fail;

  function new();
    slave_byte = '0;
    sub_addr   = '0;
    sub_left   = '0;
    sub_phase  = PHASE_NONE;
    end_state  = DONE_BUSY;
    bytes_left = '0;
    errors     = 0;
    checked    = 0;
    n_start    = 0;
    n_reject   = 0;
    n_stop     = 0;
    n_fail     = 0;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function seq_result_t sequence_step(seq_req_t r);
    seq_result_t res;
    logic [7:0]  st;
    logic [7:0]  s;
    res = '0;
    st  = r.bus_status & ST_MASK;
    if (r.action == ACT_START) begin
      n_start++;
      if (r.byte_count[COUNT_WIDTH_DEF-1:0] == '0) begin
        res.done_status = DONE_REJECT;
        n_reject++;
      end else begin
        s = r.slave_addr + {7'd0, r.is_read};
        if (r.sub_mode == MODE_NONE) begin
          sub_left  = 2'd0;
          sub_phase = PHASE_NONE;
        end else begin
          if (r.sub_mode == MODE_8X) begin
            s        = s + {4'd0, r.sub_address[10:8], 1'b0};
            sub_addr = {8'd0, r.sub_address[7:0]};
            sub_left = 2'd1;
          end else begin
            sub_addr = r.sub_address;
            sub_left = r.sub_mode;
          end
          sub_phase = r.is_read ? PHASE_READ : PHASE_WRITE;
        end
        slave_byte      = s;
        bytes_left      = r.byte_count[COUNT_WIDTH_DEF-1:0];
        end_state       = DONE_BUSY;
        res.set_start   = 1'b1;
        res.ack_control = ACK_CLEAR;
        res.clear_start = 1'b1;
        res.clear_irq   = 1'b1;
      end
    end else begin
      case (st)
        ST_START: begin
          res.load_data   = 1'b1;
          res.data_out    = (sub_phase == PHASE_READ) ? (slave_byte & 8'hFE) : slave_byte;
          res.clear_start = 1'b1;
          res.clear_irq   = 1'b1;
        end
        ST_RSTART: begin
          res.load_data   = 1'b1;
          res.data_out    = slave_byte;
          res.clear_start = 1'b1;
          res.clear_irq   = 1'b1;
        end
        ST_SLAW_ACK, ST_DATA_ACK: begin
          if (sub_phase == PHASE_NONE) begin
            if (bytes_left != '0) begin
              res.load_data = 1'b1;
              res.data_out  = r.tx_byte;
              res.took_tx   = 1'b1;
              bytes_left    = bytes_left - 1'b1;
            end else begin
              res.set_stop = 1'b1;
              end_state    = DONE_OK;
              n_stop++;
            end
            res.clear_start = 1'b1;
            res.clear_irq   = 1'b1;
          end else if (sub_phase == PHASE_READ || sub_phase == PHASE_WRITE) begin
            if (sub_left == 2'd2) begin
              res.load_data   = 1'b1;
              res.data_out    = sub_addr[15:8];
              res.clear_start = 1'b1;
              res.clear_irq   = 1'b1;
              sub_left        = 2'd1;
            end else if (sub_left == 2'd1) begin
              res.load_data   = 1'b1;
              res.data_out    = sub_addr[7:0];
              res.clear_start = 1'b1;
              res.clear_irq   = 1'b1;
              sub_left        = 2'd0;
              if (sub_phase == PHASE_WRITE) sub_phase = PHASE_NONE;
            end else if (sub_left == 2'd0 && sub_phase == PHASE_READ) begin
              res.set_start = 1'b1;
              res.clear_irq = 1'b1;
              sub_phase     = PHASE_NONE;
            end
          end
        end
        ST_SLAR_ACK: begin
          res.ack_control = (bytes_left <= 1) ? ACK_CLEAR : ACK_SET;
          res.clear_start = 1'b1;
          res.clear_irq   = 1'b1;
        end
        ST_SLAW_NACK, ST_DATA_NACK, ST_ARB_LOST, ST_SLAR_NACK: begin
          res.clear_start = 1'b1;
          res.clear_irq   = 1'b1;
          end_state       = DONE_FAIL;
          n_fail++;
        end
        ST_RX_ACK: begin
          res.rx_valid = 1'b1;
          res.rx_data  = r.rx_byte;
          // saturates at zero
          if (bytes_left != '0) bytes_left = bytes_left - 1'b1;
          res.ack_control = (bytes_left == 1) ? ACK_CLEAR : ACK_SET;
          res.clear_start = 1'b1;
          res.clear_irq   = 1'b1;
        end
        ST_RX_NACK: begin
          res.rx_valid    = 1'b1;
          res.rx_data     = r.rx_byte;
          res.set_stop    = 1'b1;
          res.clear_start = 1'b1;
          res.clear_irq   = 1'b1;
          end_state       = DONE_OK;
          n_stop++;
        end
        default: ;
      endcase
      res.done_status = end_state;
    end
    return res;
  endfunction

  function void note_request(seq_req_t r);
    pending_results.push_back(sequence_step(r));
  endfunction

  task report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task compare_field(string name, int got_v, int exp_v, int idx);
    if (got_v != exp_v)
      report_mismatch($sformatf("result %0d %s got %0h exp %0h", idx, name, got_v, exp_v));
  endtask

  task check_result(seq_result_t got);
    seq_result_t e;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %0d with no request waiting", checked));
    end else begin
      e = pending_results.pop_front();
      compare_field("load_data",   got.load_data,   e.load_data,   checked);
      compare_field("data_out",    got.data_out,    e.data_out,    checked);
      compare_field("took_tx",     got.took_tx,     e.took_tx,     checked);
      compare_field("rx_valid",    got.rx_valid,    e.rx_valid,    checked);
      compare_field("rx_data",     got.rx_data,     e.rx_data,     checked);
      compare_field("set_start",   got.set_start,   e.set_start,   checked);
      compare_field("set_stop",    got.set_stop,    e.set_stop,    checked);
      compare_field("ack_control", got.ack_control, e.ack_control, checked);
      compare_field("clear_start", got.clear_start, e.clear_start, checked);
      compare_field("clear_irq",   got.clear_irq,   e.clear_irq,   checked);
      compare_field("done_status", got.done_status, e.done_status, checked);
    end
    checked++;
  endtask
endclass

module i2c_master_subaddr_sequencer_tb;

  localparam int ITEMS_TOTAL = 1550;
  localparam int LONG_HOLD   = 64;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [7:0]  in_slave_addr;
  logic        in_is_read;
  logic [1:0]  in_sub_mode;
  logic [15:0] in_sub_address;
  logic [15:0] in_byte_count;
  logic [7:0]  in_bus_status;
  logic [7:0]  in_rx_byte;
  logic [7:0]  in_tx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_load_data;
  logic [7:0]  out_data_out;
  logic        out_took_tx;
  logic        out_rx_valid;
  logic [7:0]  out_rx_data;
  logic        out_set_start;
  logic        out_set_stop;
  logic [1:0]  out_ack_control;
  logic        out_clear_start;
  logic        out_clear_irq;
  logic [1:0]  out_done_status;

  seq_scoreboard sb;
  int            n_sent;
  bit            quiet;
  bit            hold_out;
  bit            hold_used;
  bit            drain_used;

  i2c_master_subaddr_sequencer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_slave_addr   (in_slave_addr),
    .in_is_read      (in_is_read),
    .in_sub_mode     (in_sub_mode),
    .in_sub_address  (in_sub_address),
    .in_byte_count   (in_byte_count),
    .in_bus_status   (in_bus_status),
    .in_rx_byte      (in_rx_byte),
    .in_tx_byte      (in_tx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_load_data   (out_load_data),
    .out_data_out    (out_data_out),
    .out_took_tx     (out_took_tx),
    .out_rx_valid    (out_rx_valid),
    .out_rx_data     (out_rx_data),
    .out_set_start   (out_set_start),
    .out_set_stop    (out_set_stop),
    .out_ack_control (out_ack_control),
    .out_clear_start (out_clear_start),
    .out_clear_irq   (out_clear_irq),
    .out_done_status (out_done_status)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial sb = new();

  always @(posedge clk) begin
    seq_req_t r;
    if (rst_n && in_valid && in_ready) begin
      r.action      = in_action;
      r.slave_addr  = in_slave_addr;
      r.is_read     = in_is_read;
      r.sub_mode    = in_sub_mode;
      r.sub_address = in_sub_address;
      r.byte_count  = in_byte_count;
      r.bus_status  = in_bus_status;
      r.rx_byte     = in_rx_byte;
      r.tx_byte     = in_tx_byte;
      sb.note_request(r);
    end
  end

  always @(posedge clk) begin
    seq_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.load_data   = out_load_data;
      got.data_out    = out_data_out;
      got.took_tx     = out_took_tx;
      got.rx_valid    = out_rx_valid;
      got.rx_data     = out_rx_data;
      got.set_start   = out_set_start;
      got.set_stop    = out_set_stop;
      got.ack_control = out_ack_control;
      got.clear_start = out_clear_start;
      got.clear_irq   = out_clear_irq;
      got.done_status = out_done_status;
      sb.check_result(got);
    end
  end

  // result side back-pressure
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_out = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", sb.pending());
    $display("== FAIL ==");
    $finish;
  end

  function automatic seq_req_t rand_fields();
    seq_req_t r;
    r.action      = 1'($urandom);
    r.slave_addr  = 8'($urandom);
    r.is_read     = 1'($urandom);
    r.sub_mode    = 2'($urandom);
    r.sub_address = 16'($urandom);
    r.byte_count  = 16'($urandom);
    r.bus_status  = 8'($urandom);
    r.rx_byte     = 8'($urandom);
    r.tx_byte     = 8'($urandom);
    return r;
  endfunction

  function automatic seq_req_t start_req(logic [7:0] sla, logic rd, logic [1:0] mode,
                                         logic [15:0] sub, logic [15:0] cnt);
    seq_req_t r;
    r             = rand_fields();
    r.action      = ACT_START;
    r.slave_addr  = sla;
    r.is_read     = rd;
    r.sub_mode    = mode;
    r.sub_address = sub;
    r.byte_count  = cnt;
    return r;
  endfunction

  function automatic seq_req_t event_req(logic [7:0] st);
    seq_req_t r;
    r            = rand_fields();
    r.action     = ACT_EVENT;
    r.bus_status = (st & ST_MASK) | 8'($urandom_range(0, 7));
    return r;
  endfunction

  function automatic logic [7:0] pick_failure();
    case ($urandom_range(0, 3))
      0:       return ST_SLAW_NACK;
      1:       return ST_DATA_NACK;
      2:       return ST_ARB_LOST;
      default: return ST_SLAR_NACK;
    endcase
  endfunction

  // entered and left just after a falling edge
  task automatic send_request(input seq_req_t r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_action      <= r.action;
    in_slave_addr  <= r.slave_addr;
    in_is_read     <= r.is_read;
    in_sub_mode    <= r.sub_mode;
    in_sub_address <= r.sub_address;
    in_byte_count  <= r.byte_count;
    in_bus_status  <= r.bus_status;
    in_rx_byte     <= r.rx_byte;
    in_tx_byte     <= r.tx_byte;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic run_transaction();
    logic [7:0]  sla;
    logic        rd;
    logic [1:0]  mode;
    logic [15:0] sub;
    logic [15:0] cnt;
    int          nsub;
    int          k;
    int          cut;
    logic [7:0]  plan[$];
    sla  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : (8'($urandom) & 8'hFE);
    rd   = 1'($urandom);
    mode = 2'($urandom);
    sub  = 16'($urandom);
    cnt  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
    nsub = (mode == MODE_NONE) ? 0 : (mode == MODE_8X) ? 1 : int'(mode);
    plan.push_back(ST_START);
    if (!rd) begin
      plan.push_back(ST_SLAW_ACK);
      for (k = 0; k < nsub + int'(cnt) && k < 24; k++) plan.push_back(ST_DATA_ACK);
    end else begin
      if (nsub > 0) begin
        plan.push_back(ST_SLAW_ACK);
        for (k = 0; k < nsub; k++) plan.push_back(ST_DATA_ACK);
        plan.push_back(ST_RSTART);
      end
      plan.push_back(ST_SLAR_ACK);
      for (k = 1; k < int'(cnt) && k < 24; k++) plan.push_back(ST_RX_ACK);
      plan.push_back(ST_RX_NACK);
    end
    // long counts and some short ones are cut part way, most ending in a bus error
    if (cnt > 16'd20 || $urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, plan.size() - 1);
      while (plan.size() > cut) void'(plan.pop_back());
      if ($urandom_range(0, 3) != 0) plan.push_back(pick_failure());
    end
    send_request(start_req(sla, rd, mode, sub, cnt));
    foreach (plan[i]) begin
      if ($urandom_range(0, 29) == 0) send_request(event_req(8'($urandom)));
      send_request(event_req(plan[i]));
    end
  endtask

  initial begin : stimulus
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_START;
    in_slave_addr  = '0;
    in_is_read     = 1'b0;
    in_sub_mode    = MODE_NONE;
    in_sub_address = '0;
    in_byte_count  = '0;
    in_bus_status  = '0;
    in_rx_byte     = '0;
    in_tx_byte     = '0;
    n_sent         = 0;
    quiet          = 1'b0;
    hold_out       = 1'b0;
    hold_used      = 1'b0;
    drain_used     = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero count, receive underflow from reset, unknown codes
    send_request(start_req(8'hFF, 1'b1, MODE_8X, 16'hFFFF, 16'h0000));
    send_request(event_req(ST_RX_ACK));
    send_request(event_req(8'h00));
    send_request(event_req(8'hF8));
    // eight plus X read, slave byte wraps
    send_request(start_req(8'hFF, 1'b1, MODE_8X, 16'hFFFF, 16'hFFFF));
    send_request(event_req(ST_START));
    send_request(event_req(ST_SLAW_ACK));
    send_request(event_req(ST_DATA_ACK));
    send_request(event_req(ST_RSTART));
    send_request(event_req(ST_SLAR_ACK));
    send_request(event_req(ST_RX_ACK));
    send_request(event_req(ST_RX_NACK));
    // two-byte sub-address write of one byte
    send_request(start_req(8'h00, 1'b0, MODE_TWO, 16'hA55A, 16'h0001));
    send_request(event_req(ST_START));
    send_request(event_req(ST_SLAW_ACK));
    send_request(event_req(ST_DATA_ACK));
    send_request(event_req(ST_DATA_ACK));
    send_request(event_req(ST_DATA_ACK));
    send_request(event_req(ST_SLAW_NACK));
    // plain read of one byte, then receive past zero
    send_request(start_req(8'h7E, 1'b1, MODE_NONE, 16'h0000, 16'h0001));
    send_request(event_req(ST_START));
    send_request(event_req(ST_SLAR_ACK));
    send_request(event_req(ST_RX_ACK));
    send_request(event_req(ST_RX_ACK));
    send_request(event_req(ST_DATA_NACK));
    send_request(event_req(ST_ARB_LOST));
    send_request(event_req(ST_SLAR_NACK));
    wait_drained();

    while (n_sent < ITEMS_TOTAL) begin
      quiet = (n_sent > ITEMS_TOTAL - 150);
      if (!hold_used && n_sent > 400) begin
        hold_used = 1'b1;
        hold_out  = 1'b1;
      end
      if (!drain_used && n_sent > 800) begin
        drain_used = 1'b1;
        wait_drained();
      end
      if ($urandom_range(0, 9) == 0) send_request(rand_fields());
      else run_transaction();
    end

    in_valid <= 1'b0;
    for (int w = 0; w < 2000 && sb.pending() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    $display("Sent %0d requests: %0d starts (%0d rejected), %0d stops, %0d bus failures",
             n_sent, sb.n_start, sb.n_reject, sb.n_stop, sb.n_fail);
    $display("Checked %0d results, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/i2cms_pkg.sv
src/i2cms_step.sv
src/i2c_master_subaddr_sequencer.sv
src/i2cms_checker.sv
bench/i2c_master_subaddr_sequencer_tb.sv
